@@ hdl/cfp_pkg.sv @@
// ----------------------------------------------------------------------------
// cfp_pkg: shared definitions for the CRC checked frame parser
// Field widths, status and register codes, and the CRC16 byte update.
// ----------------------------------------------------------------------------
package cfp_pkg;

   // Largest entry count a frame may carry (1 to 16).
   localparam int MAX_ENTRIES = 3;

   localparam int BYTE_W    = 8;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 16;
   localparam int INDEX_W   = 4;
   localparam int HALF_W    = 16;
   localparam int VALUE_W   = 32;
   localparam int CRC_W     = 16;
   localparam int ENTRY_W   = 64;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_ENTRY     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_FUNC  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_COUNT = 2'd2;
   localparam logic [STATUS_W-1:0] ST_CRC_ERR   = 2'd3;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CRC_POLY     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CRC_INIT     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CRC_REFLECT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CRC_XOR_OUT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_READ    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_WRITE   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_UPGRADE = 3'd6;

   function automatic logic [7:0] rev8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[7-i] = v[i];
      end
      return r;
   endfunction

   function automatic logic [CRC_W-1:0] rev16(input logic [CRC_W-1:0] v);
      logic [CRC_W-1:0] r;
      for (int i = 0; i < CRC_W; i++) begin
         r[CRC_W-1-i] = v[i];
      end
      return r;
   endfunction

   // One byte through the CRC16 register, MSB first (LSB first when reflect is set).
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [7:0]       b,
                                                 input logic             reflect,
                                                 input logic [CRC_W-1:0] poly);
      logic [CRC_W-1:0] c;
      logic [7:0]       d;
      d = reflect ? rev8(b) : b;
      c = crc ^ {d, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ poly) : {c[CRC_W-2:0], 1'b0};
      end
      return c;
   endfunction

endpackage

@@ hdl/cfp_req_if.sv @@
// ----------------------------------------------------------------------------
// cfp_req_if: received byte channel
// Valid/ready channel carrying one received byte per item.
// ----------------------------------------------------------------------------
interface cfp_req_if import cfp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ hdl/cfp_rsp_if.sv @@
// ----------------------------------------------------------------------------
// cfp_rsp_if: parser result channel
// Valid/ready channel carrying one entry or error result per item.
// ----------------------------------------------------------------------------
interface cfp_rsp_if import cfp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [BYTE_W-1:0]   station_id;
   logic [BYTE_W-1:0]   func_code;
   logic [COUNT_W-1:0]  entry_count;
   logic [INDEX_W-1:0]  entry_index;
   logic [HALF_W-1:0]   entry_addr;
   logic [HALF_W-1:0]   entry_offset;
   logic [VALUE_W-1:0]  entry_value;
   logic                last;

   modport source (output valid, output status, output station_id, output func_code,
                   output entry_count, output entry_index, output entry_addr,
                   output entry_offset, output entry_value, output last, input ready);
   modport sink   (input valid, input status, input station_id, input func_code,
                   input entry_count, input entry_index, input entry_addr,
                   input entry_offset, input entry_value, input last, output ready);
endinterface

@@ hdl/crc_checked_frame_parser.sv @@
// ----------------------------------------------------------------------------
// crc_checked_frame_parser: CRC16 checked serial frame parser
// Parses address, function, count, 8-byte entries and a CRC16 from a byte
// stream and emits one result per entry of a good frame, or one error.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ch takes one received byte per item. It lands in an input register;
//    the parse step (phase, entry store, CRC16 byte update) runs from there
//    into the output register rsp_ch.
//  - rsp_ch gives results: per entry of a good frame (status 0, last set on
//    the final entry) after the second CRC byte, or one error item (bad
//    function on the function byte, bad count on the second count byte, CRC
//    mismatch on the second CRC byte), always with last set.
//  - Result path: a taken byte goes to the input register, then its result
//    goes to the output register.
//  - Throughput: one byte per cycle when not stalled. A good frame holds the
//    input while the output register walks the entry store.
//  - Receiver stall: the output register holds its item. Bytes that cause no
//    result keep moving; the first byte that causes one waits in the input
//    register and req_ch.ready stays low until the output register frees.
//  - Reset (synchronous): configuration returns to its defaults, the parser
//    waits for an address byte, both channels empty. No clearing pass.
//  - csr_*: write-only registers, user writes only while idle; not enforced.
// ----------------------------------------------------------------------------
module crc_checked_frame_parser import cfp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   cfp_req_if.sink               req_ch,
   cfp_rsp_if.source             rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ST_IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);
   localparam int BC_W     = 8;

   typedef enum logic [4:0] {
      PH_ADDR  = 5'b00001,
      PH_FUNC  = 5'b00010,
      PH_COUNT = 5'b00100,
      PH_DATA  = 5'b01000,
      PH_CRC   = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   station_id;
      logic [BYTE_W-1:0]   func_code;
      logic [COUNT_W-1:0]  entry_count;
      logic [INDEX_W-1:0]  entry_index;
      logic [HALF_W-1:0]   entry_addr;
      logic [HALF_W-1:0]   entry_offset;
      logic [VALUE_W-1:0]  entry_value;
      logic                last;
   } rsp_item_type;

   // ---------------- configuration registers ----------------
   logic [CRC_W-1:0]  crc_poly_ff, crc_init_ff, crc_xor_out_ff;
   logic              crc_reflect_ff;
   logic [BYTE_W-1:0] code_read_ff, code_write_ff, code_upgrade_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_poly_ff     <= 16'h8005;
         crc_init_ff     <= 16'hFFFF;
         crc_reflect_ff  <= 1'b1;
         crc_xor_out_ff  <= 16'h0000;
         code_read_ff    <= 8'd3;
         code_write_ff   <= 8'd16;
         code_upgrade_ff <= 8'd32;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CRC_POLY:     crc_poly_ff     <= csr_wdata;
            CSR_CRC_INIT:     crc_init_ff     <= csr_wdata;
            CSR_CRC_REFLECT:  crc_reflect_ff  <= csr_wdata[0];
            CSR_CRC_XOR_OUT:  crc_xor_out_ff  <= csr_wdata;
            CSR_CODE_READ:    code_read_ff    <= csr_wdata[BYTE_W-1:0];
            CSR_CODE_WRITE:   code_write_ff   <= csr_wdata[BYTE_W-1:0];
            CSR_CODE_UPGRADE: code_upgrade_ff <= csr_wdata[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- input register ----------------
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              consume;

   assign req_ch.ready = !in_valid_ff || consume;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.valid && req_ch.ready) begin
         in_valid_ff <= 1'b1;
      end else if (consume) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.rx_byte;
      end
   end

   // ---------------- parser state ----------------
   phase_type          phase_ff, phase_in;
   logic [BC_W-1:0]    byte_count_ff, byte_count_in;
   logic [BYTE_W-1:0]  frame_station_ff, frame_station_in;
   logic [BYTE_W-1:0]  frame_func_ff, frame_func_in;
   logic [COUNT_W-1:0] frame_count_ff, frame_count_in;
   logic [CRC_W-1:0]   running_crc_ff, running_crc_in;
   logic [CRC_W-1:0]   frozen_crc_ff, frozen_crc_in;
   logic [BYTE_W-1:0]  rx_crc_hi_ff, rx_crc_hi_in;
   logic [ENTRY_W-1:0] entry_store_ff [MAX_ENTRIES];

   // Burst walk of the entry store after a good frame
   logic               burst_active_ff;
   logic [INDEX_W-1:0] burst_idx_ff;

   // Output register
   logic               rsp_valid_ff;
   rsp_item_type       rsp_item_ff;

   logic               out_free;
   logic               emit_err, emit_good;
   logic [STATUS_W-1:0] err_status;
   logic [BYTE_W-1:0]  err_func;
   logic [COUNT_W-1:0] err_count;
   logic               store_wr;
   logic [BC_W-4:0]    store_sel;
   logic [CRC_W-1:0]   crc_base, crc_next, crc_final;
   logic [COUNT_W-1:0] count_full;
   logic               code_ok;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      phase_in         = phase_ff;
      byte_count_in    = byte_count_ff;
      frame_station_in = frame_station_ff;
      frame_func_in    = frame_func_ff;
      frame_count_in   = frame_count_ff;
      running_crc_in   = running_crc_ff;
      frozen_crc_in    = frozen_crc_ff;
      rx_crc_hi_in     = rx_crc_hi_ff;
      emit_err         = 1'b0;
      emit_good        = 1'b0;
      err_status       = ST_ENTRY;
      err_func         = frame_func_ff;
      err_count        = frame_count_ff;
      store_wr         = 1'b0;
      store_sel        = byte_count_ff[BC_W-1:3];

      // A new frame restarts the CRC from crc_init.
      crc_base   = (phase_ff == PH_FUNC || phase_ff == PH_COUNT || phase_ff == PH_DATA ||
                    phase_ff == PH_CRC) ? running_crc_ff : crc_init_ff;
      crc_next   = crc_byte(crc_base, in_byte_ff, crc_reflect_ff, crc_poly_ff);
      crc_final  = (crc_reflect_ff ? rev16(crc_next) : crc_next) ^ crc_xor_out_ff;
      count_full = {frame_count_ff[COUNT_W-1:BYTE_W], in_byte_ff};
      code_ok    = (in_byte_ff == code_read_ff) || (in_byte_ff == code_write_ff) ||
                   (in_byte_ff == code_upgrade_ff);

      unique case (phase_ff)
         PH_FUNC: begin
            if (!code_ok) begin
               emit_err   = 1'b1;
               err_status = ST_BAD_FUNC;
               err_func   = in_byte_ff;
               err_count  = '0;
               phase_in   = PH_ADDR;
            end else begin
               frame_func_in  = in_byte_ff;
               running_crc_in = crc_next;
               phase_in       = PH_COUNT;
               byte_count_in  = '0;
            end
         end
         PH_COUNT: begin
            running_crc_in = crc_next;
            if (byte_count_ff == '0) begin
               frame_count_in = {in_byte_ff, 8'h00};
               byte_count_in  = BC_W'(1);
            end else begin
               frame_count_in = count_full;
               byte_count_in  = '0;
               if (count_full == '0 || count_full > COUNT_W'(MAX_ENTRIES)) begin
                  emit_err   = 1'b1;
                  err_status = ST_BAD_COUNT;
                  err_count  = count_full;
                  phase_in   = PH_ADDR;
               end else begin
                  phase_in = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            store_wr       = (store_sel < (BC_W-3)'(MAX_ENTRIES));
            running_crc_in = crc_next;
            byte_count_in  = BC_W'(byte_count_ff + 1'b1);
            if (({1'b0, byte_count_ff} + 9'd1) >= (9'(frame_count_ff[CNT_W-1:0]) << 3)) begin
               frozen_crc_in = crc_final;
               phase_in      = PH_CRC;
               byte_count_in = '0;
            end
         end
         PH_CRC: begin
            if (byte_count_ff == '0) begin
               rx_crc_hi_in  = in_byte_ff;
               byte_count_in = BC_W'(1);
            end else begin
               byte_count_in = '0;
               phase_in      = PH_ADDR;
               if ({rx_crc_hi_ff, in_byte_ff} != frozen_crc_ff) begin
                  emit_err   = 1'b1;
                  err_status = ST_CRC_ERR;
               end else begin
                  emit_good = 1'b1;
               end
            end
         end
         default: begin
            // address byte, and any stray phase code
            frame_station_in = in_byte_ff;
            running_crc_in   = crc_next;
            byte_count_in    = '0;
            phase_in         = PH_FUNC;
         end
      endcase
   end

   // Input item moves on when no burst is running and its result has a slot.
   assign consume = in_valid_ff && !burst_active_ff &&
                    (!(emit_err || emit_good) || out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_ADDR;
         byte_count_ff <= '0;
      end else if (consume) begin
         phase_ff      <= phase_in;
         byte_count_ff <= byte_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_station_ff <= '0;
         frame_func_ff    <= '0;
         frame_count_ff   <= '0;
         running_crc_ff   <= '0;
         frozen_crc_ff    <= '0;
         rx_crc_hi_ff     <= '0;
      end else if (consume) begin
         frame_station_ff <= frame_station_in;
         frame_func_ff    <= frame_func_in;
         frame_count_ff   <= frame_count_in;
         running_crc_ff   <= running_crc_in;
         frozen_crc_ff    <= frozen_crc_in;
         rx_crc_hi_ff     <= rx_crc_hi_in;
      end
   end

   // Entries shift in big-endian, one byte at a time.
   always_ff @(posedge clock) begin
      if (consume && store_wr) begin
         entry_store_ff[store_sel[ST_IDX_W-1:0]] <=
            {entry_store_ff[store_sel[ST_IDX_W-1:0]][ENTRY_W-9:0], in_byte_ff};
      end
   end

   // ---------------- result assembly ----------------
   logic [INDEX_W-1:0] entry_sel;
   logic [ENTRY_W-1:0] entry_word;
   rsp_item_type       entry_item, err_item;

   always_comb begin
      entry_sel  = burst_active_ff ? burst_idx_ff : '0;
      entry_word = entry_store_ff[entry_sel[ST_IDX_W-1:0]];

      entry_item.status       = ST_ENTRY;
      entry_item.station_id   = frame_station_ff;
      entry_item.func_code    = frame_func_ff;
      entry_item.entry_count  = frame_count_ff;
      entry_item.entry_index  = entry_sel;
      entry_item.entry_addr   = entry_word[63:48];
      entry_item.entry_offset = entry_word[47:32];
      entry_item.entry_value  = entry_word[31:0];
      entry_item.last         = ((COUNT_W'(entry_sel) + 16'd1) == frame_count_ff);

      err_item.status       = err_status;
      err_item.station_id   = frame_station_ff;
      err_item.func_code    = err_func;
      err_item.entry_count  = err_count;
      err_item.entry_index  = '0;
      err_item.entry_addr   = '0;
      err_item.entry_offset = '0;
      err_item.entry_value  = '0;
      err_item.last         = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff    <= 1'b0;
         burst_active_ff <= 1'b0;
         burst_idx_ff    <= '0;
      end else if (consume && emit_err) begin
         rsp_valid_ff <= 1'b1;
      end else if (consume && emit_good) begin
         rsp_valid_ff    <= 1'b1;
         burst_active_ff <= !entry_item.last;
         burst_idx_ff    <= INDEX_W'(1);
      end else if (burst_active_ff && out_free) begin
         rsp_valid_ff    <= 1'b1;
         burst_active_ff <= !entry_item.last;
         burst_idx_ff    <= INDEX_W'(burst_idx_ff + 1'b1);
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (consume && emit_err) begin
         rsp_item_ff <= err_item;
      end else if ((consume && emit_good) || (burst_active_ff && out_free)) begin
         rsp_item_ff <= entry_item;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_item_ff.status;
   assign rsp_ch.station_id   = rsp_item_ff.station_id;
   assign rsp_ch.func_code    = rsp_item_ff.func_code;
   assign rsp_ch.entry_count  = rsp_item_ff.entry_count;
   assign rsp_ch.entry_index  = rsp_item_ff.entry_index;
   assign rsp_ch.entry_addr   = rsp_item_ff.entry_addr;
   assign rsp_ch.entry_offset = rsp_item_ff.entry_offset;
   assign rsp_ch.entry_value  = rsp_item_ff.entry_value;
   assign rsp_ch.last         = rsp_item_ff.last;

`ifndef SYNTH
   // A burst never overlaps parsing of the next byte.
   a_burst_blocks_input: assert property (@(posedge clock) disable iff (reset)
      burst_active_ff |-> !consume)
      else $error("input consumed during entry burst");

   // A burst only runs after the parser has returned to address wait.
   a_burst_phase: assert property (@(posedge clock) disable iff (reset)
      burst_active_ff |-> (phase_ff == PH_ADDR))
      else $error("entry burst outside address phase");

   // Burst index stays inside the frame's entry count.
   a_burst_index: assert property (@(posedge clock) disable iff (reset)
      burst_active_ff |-> (COUNT_W'(burst_idx_ff) < frame_count_ff))
      else $error("burst index past entry count");

   // Error results always close their byte's results.
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.status != ST_ENTRY) |-> rsp_item_ff.last)
      else $error("error result without last");

   // Data phase only ever follows a legal entry count.
   a_data_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |->
         (frame_count_ff != '0 && frame_count_ff <= COUNT_W'(MAX_ENTRIES)))
      else $error("data phase with illegal count");
`endif

endmodule
